// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition checked on every rising clock edge outside reset
`define CHK_IMPLY(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// next-cycle implication checked outside reset
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/tcsd_pkg.sv =====
// ----------------------------------------------------------------------------
// tcsd_pkg
// shared constants, types and the cordic arctangent table
// ----------------------------------------------------------------------------
`default_nettype none
package tcsd_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int CORDIC_STEPS_DEF = 14;
  localparam int ANGLE_W = 15;
  localparam int THR_W = 15;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_NOISE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SWING = 1'b1;

  localparam logic [THR_W-1:0] NOISE_RESET = 15'd1024;
  localparam logic [THR_W-1:0] SWING_RESET = 15'd1536;

  typedef enum logic [1:0] {
    MOVE_LEFT  = 2'd0,
    MOVE_RIGHT = 2'd1,
    MOVE_DOWN  = 2'd2,
    MOVE_NONE  = 2'd3
  } move_t;

  // cordic working widths: angle in 2^-18 degree, x/y in q30
  localparam int ZW = 30;
  localparam int CW = 34;
  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [ZW-1:0] DEG180 = 30'sd47185920;
  localparam logic signed [ZW-1:0] DEG90  = 30'sd23592960;
  localparam logic signed [ZW-1:0] DEG360 = 30'sd94371840;

  function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] i);
    logic signed [ZW-1:0] r;
    begin
      case (i)
        5'd0: r = 30'sd11796480;  5'd1: r = 30'sd6963869;
        5'd2: r = 30'sd3679517;   5'd3: r = 30'sd1867780;
        5'd4: r = 30'sd937515;    5'd5: r = 30'sd469214;
        5'd6: r = 30'sd234664;    5'd7: r = 30'sd117339;
        5'd8: r = 30'sd58671;     5'd9: r = 30'sd29335;
        5'd10: r = 30'sd14668;    5'd11: r = 30'sd7334;
        5'd12: r = 30'sd3667;     5'd13: r = 30'sd1833;
        5'd14: r = 30'sd917;      5'd15: r = 30'sd458;
        5'd16: r = 30'sd229;      5'd17: r = 30'sd115;
        5'd18: r = 30'sd57;       5'd19: r = 30'sd29;
        5'd20: r = 30'sd14;       5'd21: r = 30'sd7;
        5'd22: r = 30'sd4;        5'd23: r = 30'sd2;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

  typedef enum logic [2:0] {
    ST_IDLE, ST_CORDIC, ST_MUL, ST_FINAL, ST_OUT
  } back_state_t;

endpackage
`default_nettype wire

// ===== rtl/tilt_compensated_swipe_detector_top.sv =====
// the back end works on one sample at a time and takes the next only after the
// result is taken, so an output stall holds it; one shared cordic and one
// multiplier run all three angles and the twelve products in turn; a two-entry
// queue takes samples meanwhile
// reset: synchronous, thresholds to 1024/1536, history to rest at one g
`default_nettype none
module tilt_compensated_swipe_detector_top #(
  parameter int SAMPLE_WIDTH = tcsd_pkg::SAMPLE_WIDTH_DEF,
  parameter int CORDIC_STEPS = tcsd_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [tcsd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tcsd_pkg::THR_W-1:0] cfg_data,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic signed [SAMPLE_WIDTH-1:0] accel_x,
  input  wire logic signed [SAMPLE_WIDTH-1:0] accel_y,
  input  wire logic signed [SAMPLE_WIDTH-1:0] accel_z,
  input  wire logic signed [tcsd_pkg::ANGLE_W-1:0] pitch_angle,
  input  wire logic signed [tcsd_pkg::ANGLE_W-1:0] roll_angle,
  input  wire logic signed [tcsd_pkg::ANGLE_W-1:0] yaw_angle,
  output logic      out_valid,
  input  wire logic out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] free_x,
  output logic signed [SAMPLE_WIDTH-1:0] free_y,
  output logic signed [SAMPLE_WIDTH-1:0] free_z,
  output logic [1:0] gesture,
  output logic       gesture_new
);
  localparam int DW = 3*SAMPLE_WIDTH + 3*tcsd_pkg::ANGLE_W;

  logic [tcsd_pkg::THR_W-1:0] noise_thr, swing_thr;
  logic q_valid, q_ready;
  logic [DW-1:0] q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      noise_thr <= tcsd_pkg::NOISE_RESET;
      swing_thr <= tcsd_pkg::SWING_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tcsd_pkg::REG_NOISE: noise_thr <= cfg_data;
        tcsd_pkg::REG_SWING: swing_thr <= cfg_data;
        default: ;
      endcase
    end
  end

  tcsd_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
    .clk, .rst, .in_valid, .in_ready,
    .in_data({accel_x, accel_y, accel_z, pitch_angle, roll_angle, yaw_angle}),
    .q_valid, .q_ready, .q_data
  );

  tcsd_back #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_data, .noise_thr, .swing_thr,
    .out_valid, .out_ready, .free_x, .free_y, .free_z, .gesture, .gesture_new
  );
endmodule
`default_nettype wire

// ===== rtl/tcsd_front.sv =====
// ----------------------------------------------------------------------------
// tcsd_front
// two-entry queue holding accepted samples until the back end takes them
// ----------------------------------------------------------------------------
`default_nettype none
module tcsd_front #(
  parameter int SAMPLE_WIDTH = tcsd_pkg::SAMPLE_WIDTH_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire logic [3*SAMPLE_WIDTH+3*tcsd_pkg::ANGLE_W-1:0] in_data,
  output logic      q_valid,
  input  wire logic q_ready,
  output logic [3*SAMPLE_WIDTH+3*tcsd_pkg::ANGLE_W-1:0] q_data
);
  localparam int DW = 3*SAMPLE_WIDTH + 3*tcsd_pkg::ANGLE_W;

  logic [DW-1:0] mem [2];
  logic          wr_ptr, rd_ptr;
  logic [1:0]    count;
  logic          push, pop;

  assign in_ready = (count != 2'd2);
  assign q_valid  = (count != 2'd0);
  assign q_data   = mem[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

// ===== rtl/tcsd_back.sv =====
// ----------------------------------------------------------------------------
// tcsd_back
// shared cordic for three angles, sequential rotation products, detection
// ----------------------------------------------------------------------------
`default_nettype none
module tcsd_back #(
  parameter int SAMPLE_WIDTH = tcsd_pkg::SAMPLE_WIDTH_DEF,
  parameter int CORDIC_STEPS = tcsd_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_valid,
  output logic      q_ready,
  input  wire logic [3*SAMPLE_WIDTH+3*tcsd_pkg::ANGLE_W-1:0] q_data,
  input  wire logic [tcsd_pkg::THR_W-1:0] noise_thr,
  input  wire logic [tcsd_pkg::THR_W-1:0] swing_thr,
  output logic      out_valid,
  input  wire logic out_ready,
  output logic signed [SAMPLE_WIDTH-1:0] free_x,
  output logic signed [SAMPLE_WIDTH-1:0] free_y,
  output logic signed [SAMPLE_WIDTH-1:0] free_z,
  output logic [1:0] gesture,
  output logic       gesture_new
);
  localparam int SW = SAMPLE_WIDTH;
  localparam int AW = tcsd_pkg::ANGLE_W;
  localparam int ZW = tcsd_pkg::ZW;
  localparam int CW = tcsd_pkg::CW;
  localparam int STEPS = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
  // vector in q8, products of q8 by q20
  localparam int VW = SW + 12;
  localparam int PW = VW + 23;
  localparam int TW = SW + 3;
  // deltas wide enough for both the samples and the thresholds
  localparam int DXW = ((SW > tcsd_pkg::THR_W) ? SW : tcsd_pkg::THR_W) + 2;

  tcsd_pkg::back_state_t state, state_next;

  logic signed [SW-1:0] ax, ay, az;
  logic signed [AW-1:0] ang [3];
  logic [1:0] ang_sel;
  logic [4:0] it;
  logic signed [ZW-1:0] z;
  logic signed [CW-1:0] cx, cy;
  logic flip;
  logic signed [22:0] sn [3];
  logic signed [22:0] cs [3];
  logic signed [VW-1:0] v0, v1, v2;
  logic signed [VW-1:0] held;
  logic [2:0] mstep;
  logic signed [PW-1:0] pa, pb;
  logic [1:0] mphase;
  logic signed [SW-1:0] prev_x;
  logic signed [DXW-1:0] prev_z;
  logic [1:0] recent_move, shown_move;

  // cordic set-up: wrap and fold the selected angle
  logic signed [ZW-1:0] z0, zw;
  logic fl0;
  always_comb begin
    zw = ZW'(ang[ang_sel]) * 30'sd4096;
    if (ang_sel == 2'd0) zw = -zw;
    fl0 = 1'b0;
    if (zw > tcsd_pkg::DEG180) zw = zw - tcsd_pkg::DEG360;
    else if (zw <= -tcsd_pkg::DEG180) zw = zw + tcsd_pkg::DEG360;
    z0 = zw;
    if (zw > tcsd_pkg::DEG90) begin
      z0 = zw - tcsd_pkg::DEG180;
      fl0 = 1'b1;
    end else if (zw < -tcsd_pkg::DEG90) begin
      z0 = zw + tcsd_pkg::DEG180;
      fl0 = 1'b1;
    end
  end

  logic signed [CW-1:0] sx, sy;
  logic signed [22:0] rc, rs;
  logic signed [CW-1:0] rcw, rsw;
  assign sx = cx >>> it;
  assign sy = cy >>> it;
  assign rcw = (cx + 34'sd512) >>> 10;
  assign rsw = (cy + 34'sd512) >>> 10;
  assign rc = flip ? -rcw[22:0] : rcw[22:0];
  assign rs = flip ? -rsw[22:0] : rsw[22:0];

  // one dot product term at a time: operands chosen by mstep/mphase
  logic signed [VW-1:0] ma;
  logic signed [22:0] mc;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] dsum;
  logic signed [VW-1:0] dres;
  always_comb begin
    ma = v0;
    mc = cs[2];
    case (mstep)
      3'd0: begin ma = mphase[0] ? v1 : v0; mc = mphase[0] ? sn[2] : cs[2]; end
      3'd1: begin ma = mphase[0] ? v1 : v0; mc = mphase[0] ? cs[2] : -sn[2]; end
      3'd2: begin ma = mphase[0] ? v2 : v0; mc = mphase[0] ? -sn[1] : cs[1]; end
      3'd3: begin ma = mphase[0] ? v2 : v0; mc = mphase[0] ? cs[1] : sn[1]; end
      3'd4: begin ma = mphase[0] ? v2 : v1; mc = mphase[0] ? sn[0] : cs[0]; end
      3'd5: begin ma = mphase[0] ? v2 : v1; mc = mphase[0] ? cs[0] : -sn[0]; end
      default: begin ma = v0; mc = cs[2]; end
    endcase
    prod = PW'(ma) * PW'(mc);
    dsum = pa + pb + (PW'(1) <<< 19);
    dres = VW'(dsum >>> 20);
  end

  // final rounding, saturation and detection
  localparam logic signed [TW-1:0] SMAX = TW'((longint'(1) << (SW-1)) - 1);
  localparam logic signed [TW-1:0] SMIN = -TW'(longint'(1) << (SW-1));
  function automatic logic signed [SW-1:0] satr(input logic signed [VW-1:0] v,
                                                input logic sub1g);
    logic signed [VW-1:0] r;
    logic signed [TW-1:0] t;
    begin
      r = (v + VW'(128)) >>> 8;
      if (sub1g) r = r - VW'(1024);
      if (r > VW'(SMAX)) t = SMAX;
      else if (r < VW'(SMIN)) t = SMIN;
      else t = TW'(r);
      return t[SW-1:0];
    end
  endfunction

  logic signed [SW-1:0] fx, fy, fz;
  logic signed [DXW-1:0] dx, dz, adx, adz, nthr, sthr;
  logic moved;
  logic [1:0] move_next;
  always_comb begin
    fx = satr(v0, 1'b0);
    fy = satr(v1, 1'b0);
    fz = satr(v2, 1'b1);
    nthr = DXW'(noise_thr);
    sthr = DXW'(swing_thr);
    dx = DXW'(prev_x) - DXW'(fx);
    dz = prev_z - DXW'(fz);
    adx = dx[DXW-1] ? -dx : dx;
    adz = dz[DXW-1] ? -dz : dz;
    moved = 1'b0;
    move_next = tcsd_pkg::MOVE_NONE;
    if (adz > nthr) begin
      moved = 1'b1;
      move_next = tcsd_pkg::MOVE_DOWN;
    end else if (adx > nthr) begin
      if (dx > sthr && recent_move != tcsd_pkg::MOVE_RIGHT) begin
        moved = 1'b1;
        move_next = tcsd_pkg::MOVE_LEFT;
      end else if (dx < -sthr && recent_move != tcsd_pkg::MOVE_LEFT) begin
        moved = 1'b1;
        move_next = tcsd_pkg::MOVE_RIGHT;
      end
    end
  end

  logic cordic_last, mul_last;
  assign cordic_last = (it == 5'(STEPS)) && (ang_sel == 2'd2);
  assign mul_last = (mstep == 3'd5) && (mphase == 2'd2);

  always_comb begin
    state_next = state;
    case (state)
      tcsd_pkg::ST_IDLE:   if (q_valid) state_next = tcsd_pkg::ST_CORDIC;
      tcsd_pkg::ST_CORDIC: if (cordic_last) state_next = tcsd_pkg::ST_MUL;
      tcsd_pkg::ST_MUL:    if (mul_last) state_next = tcsd_pkg::ST_FINAL;
      tcsd_pkg::ST_FINAL:  state_next = tcsd_pkg::ST_OUT;
      tcsd_pkg::ST_OUT:    if (out_ready) state_next = tcsd_pkg::ST_IDLE;
      default:             state_next = tcsd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_ready   = (state == tcsd_pkg::ST_IDLE);
    out_valid = (state == tcsd_pkg::ST_OUT);
  end

  always_ff @(posedge clk) begin
    case (state)
      tcsd_pkg::ST_IDLE: begin
        {ax, ay, az} <= q_data[3*SW+3*AW-1:3*AW];
        ang[0] <= q_data[3*AW-1:2*AW];
        ang[1] <= q_data[2*AW-1:AW];
        ang[2] <= q_data[AW-1:0];
        it <= 5'd31;
        ang_sel <= 2'd0;
      end
      tcsd_pkg::ST_CORDIC: begin
        if (it == 5'd31 || it == 5'(STEPS)) begin
          if (it == 5'(STEPS)) begin
            sn[ang_sel] <= rs;
            cs[ang_sel] <= rc;
            ang_sel <= ang_sel + 2'd1;
          end
          // after the last step store sine/cosine and step the selector; at 31 load a fresh angle
          it <= (it == 5'(STEPS)) ? 5'd31 : 5'd0;
          cx <= tcsd_pkg::CORDIC_GAIN;
          cy <= '0;
          z  <= (it == 5'(STEPS)) ? '0 : z0;
          flip <= fl0;
        end else begin
          if (!z[ZW-1]) begin
            cx <= cx - sy;
            cy <= cy + sx;
            z  <= z - tcsd_pkg::atan_lut(it);
          end else begin
            cx <= cx + sy;
            cy <= cy - sx;
            z  <= z + tcsd_pkg::atan_lut(it);
          end
          it <= it + 5'd1;
        end
        v0 <= VW'(ax) <<< 8;
        v1 <= VW'(ay) <<< 8;
        v2 <= VW'(az) <<< 8;
        mstep <= 3'd0;
        mphase <= 2'd0;
      end
      tcsd_pkg::ST_MUL: begin
        if (mphase == 2'd0) begin
          pa <= prod;
          mphase <= 2'd1;
        end else if (mphase == 2'd1) begin
          pb <= prod;
          mphase <= 2'd2;
        end else begin
          // odd steps write back the pair computed over two dot products
          case (mstep)
            3'd1: begin v0 <= held; v1 <= dres; end
            3'd3: begin v0 <= held; v2 <= dres; end
            3'd5: begin v1 <= held; v2 <= dres; end
            default: held <= dres;
          endcase
          mstep <= mstep + 3'd1;
          mphase <= 2'd0;
        end
      end
      tcsd_pkg::ST_FINAL: begin
        free_x <= fx;
        free_y <= fy;
        free_z <= fz;
        gesture_new <= moved;
      end
      default: ;
    endcase
    if (rst) begin
      state <= tcsd_pkg::ST_IDLE;
      prev_x <= '0;
      prev_z <= DXW'(1024);
      recent_move <= tcsd_pkg::MOVE_NONE;
      shown_move <= tcsd_pkg::MOVE_NONE;
      gesture <= tcsd_pkg::MOVE_NONE;
    end else begin
      state <= state_next;
      if (state == tcsd_pkg::ST_FINAL) begin
        prev_x <= fx;
        prev_z <= DXW'(fz);
        recent_move <= move_next;
        if (moved) begin
          shown_move <= move_next;
          gesture <= move_next;
        end else begin
          gesture <= shown_move;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/tcsd_checker.sv =====
// ----------------------------------------------------------------------------
// tcsd_checker
// port-level checks on the swipe detector
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module tcsd_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [1:0] gesture,
  input wire logic gesture_new
);
  `CHK_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid, "result dropped")
  `CHK_IMPLY(a_new_move, clk, rst, !(out_valid && gesture_new && gesture == tcsd_pkg::MOVE_NONE), "new move shown as none")
  `CHK_NEXT(a_one_out, clk, rst, out_valid && out_ready, !out_valid, "result repeated")
endmodule

bind tilt_compensated_swipe_detector_top tcsd_checker u_chk (
  .clk, .rst, .out_valid, .out_ready, .gesture, .gesture_new
);
`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: tilt-compensated swipe detector
// drives sensor samples through the valid/ready input, rebuilds the tilt
// compensation and gesture tracking in a behavioural predictor, and checks
// every output transaction field by field against it
// ----------------------------------------------------------------------------
module tb;

  localparam int SW = tcsd_pkg::SAMPLE_WIDTH_DEF;
  localparam int AW = tcsd_pkg::ANGLE_W;
  localparam int STEPS = tcsd_pkg::CORDIC_STEPS_DEF;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct {
    logic signed [SW-1:0] fx;
    logic signed [SW-1:0] fy;
    logic signed [SW-1:0] fz;
    tcsd_pkg::move_t mv;
    logic fresh;
  } motion_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [tcsd_pkg::CFG_IDX_W-1:0] cfg_index = tcsd_pkg::REG_NOISE;
  logic [tcsd_pkg::THR_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SW-1:0] accel_x = '0, accel_y = '0, accel_z = '0;
  logic signed [AW-1:0] pitch_angle = '0, roll_angle = '0, yaw_angle = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SW-1:0] free_x, free_y, free_z;
  logic [1:0] gesture;
  logic gesture_new;

  tilt_compensated_swipe_detector_top dut (.*);

  // predictor state
  longint noise_thr = 1024, swing_thr = 1536;
  longint last_fx = 0, last_fz = 1024;
  tcsd_pkg::move_t recent_mv = tcsd_pkg::MOVE_NONE, shown_mv = tcsd_pkg::MOVE_NONE;
  motion_t pending[$];
  int errors = 0;
  longint cycles = 0;
  bit calm = 1'b0;
  int stall_left = 0;

  longint arctan_deg[24] = '{
    11796480, 6963869, 3679517, 1867780, 937515, 469214, 234664, 117339,
    58671, 29335, 14668, 7334, 3667, 1833, 917, 458,
    229, 115, 57, 29, 14, 7, 4, 2};

  initial forever #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic longint round_shift(longint v, int k);
    return (v + (longint'(1) << (k - 1))) >>> k;
  endfunction

  function automatic longint clamp_sample(longint v);
    longint hi, lo;
    hi = (longint'(1) << (SW - 1)) - 1;
    lo = -(longint'(1) << (SW - 1));
    return v > hi ? hi : (v < lo ? lo : v);
  endfunction

  // angle in 1/64 degree, sine and cosine in q20
  task automatic sin_cos(input longint ang, output longint s, output longint c);
    longint z, x, y, t;
    bit flip;
    z = ang * 4096;
    x = 652032874;
    y = 0;
    flip = 0;
    if (z > 180 * 262144) z -= 360 * 262144;
    else if (z <= -180 * 262144) z += 360 * 262144;
    if (z > 90 * 262144) begin
      z -= 180 * 262144;
      flip = 1;
    end else if (z < -90 * 262144) begin
      z += 180 * 262144;
      flip = 1;
    end
    for (int i = 0; i < STEPS && i < 24; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z -= arctan_deg[i];
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z += arctan_deg[i];
      end
      x = t;
    end
    c = round_shift(x, 10);
    s = round_shift(y, 10);
    if (flip) begin
      c = -c;
      s = -s;
    end
  endtask

  function automatic longint mac_q20(longint a, longint ca, longint b, longint cb);
    return round_shift(a * ca + b * cb, 20);
  endfunction

  task automatic predict_motion(input logic signed [SW-1:0] ax, ay, az,
                                input logic signed [AW-1:0] pa, ra, ya);
    longint v0, v1, v2, t0, t1, t2, ps, pc, rs, rc, ys, yc;
    longint fx, fy, fz, dx, dz;
    bit moved;
    motion_t m;
    moved = 0;
    v0 = longint'(ax) * 256;
    v1 = longint'(ay) * 256;
    v2 = longint'(az) * 256;
    sin_cos(-longint'(pa), ps, pc);
    sin_cos(longint'(ra), rs, rc);
    sin_cos(longint'(ya), ys, yc);
    t0 = mac_q20(v0, yc, v1, ys);
    t1 = mac_q20(v0, -ys, v1, yc);
    t2 = v2;
    v0 = mac_q20(t0, rc, t2, -rs);
    v1 = t1;
    v2 = mac_q20(t0, rs, t2, rc);
    t1 = mac_q20(v1, pc, v2, ps);
    t2 = mac_q20(v1, -ps, v2, pc);
    fx = clamp_sample(round_shift(v0, 8));
    fy = clamp_sample(round_shift(t1, 8));
    fz = clamp_sample(round_shift(t2, 8) - 1024);
    dx = last_fx - fx;
    dz = last_fz - fz;
    if ((dz < 0 ? -dz : dz) > noise_thr) begin
      recent_mv = tcsd_pkg::MOVE_DOWN;
      moved = 1;
    end else if ((dx < 0 ? -dx : dx) > noise_thr) begin
      if (dx > swing_thr && recent_mv != tcsd_pkg::MOVE_RIGHT) begin
        recent_mv = tcsd_pkg::MOVE_LEFT;
        moved = 1;
      end else if (dx < -swing_thr && recent_mv != tcsd_pkg::MOVE_LEFT) begin
        recent_mv = tcsd_pkg::MOVE_RIGHT;
        moved = 1;
      end
    end
    if (moved) shown_mv = recent_mv;
    else recent_mv = tcsd_pkg::MOVE_NONE;
    last_fx = fx;
    last_fz = fz;
    m.fx = fx[SW-1:0];
    m.fy = fy[SW-1:0];
    m.fz = fz[SW-1:0];
    m.mv = shown_mv;
    m.fresh = moved;
    pending.push_back(m);
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_sample(input int ax, ay, az, pa, ra, ya);
    int gap;
    gap = gap_len();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    accel_x <= ax[SW-1:0];
    accel_y <= ay[SW-1:0];
    accel_z <= az[SW-1:0];
    pitch_angle <= pa[AW-1:0];
    roll_angle <= ra[AW-1:0];
    yaw_angle <= ya[AW-1:0];
    do @(posedge clk); while (!in_ready);
    predict_motion(ax[SW-1:0], ay[SW-1:0], az[SW-1:0],
                   pa[AW-1:0], ra[AW-1:0], ya[AW-1:0]);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending.size() == 0);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [tcsd_pkg::CFG_IDX_W-1:0] idx,
                                 input int val);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[tcsd_pkg::THR_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == tcsd_pkg::REG_NOISE) noise_thr = val;
    else swing_thr = val;
  endtask

  task automatic report_mismatch(input string what, input longint got, want);
    $display("tb: %s mismatch at cycle %0d: got %0d, want %0d", what, cycles, got, want);
    errors++;
  endtask

  // receiver side: random stalls, some long
  always @(negedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= ($urandom_range(0, 99) < 70);
      if ($urandom_range(0, 99) < 3) stall_left <= $urandom_range(10, 50);
    end
  end

  always @(posedge clk) begin
    motion_t w;
    if (!rst && out_valid && out_ready) begin
      if (pending.size() == 0) begin
        report_mismatch("unexpected transaction", 1, 0);
      end else begin
        w = pending.pop_front();
        if (free_x !== w.fx) report_mismatch("free_x", free_x, w.fx);
        if (free_y !== w.fy) report_mismatch("free_y", free_y, w.fy);
        if (free_z !== w.fz) report_mismatch("free_z", free_z, w.fz);
        if (gesture !== w.mv) report_mismatch("gesture", gesture, w.mv);
        if (gesture_new !== w.fresh) report_mismatch("gesture_new", gesture_new, w.fresh);
      end
    end
  end

  // field extremes and angles at and beyond the quarter and half turns
  task automatic test_extremes();
    send_sample(32767, 32767, 32767, 0, 0, 0);
    send_sample(-32768, -32768, -32768, 0, 0, 0);
    send_sample(32767, -32768, 32767, 16383, -16384, 16383);
    send_sample(1000, -2000, 1024, 5760, -5760, 0);
    send_sample(1000, -2000, 1024, 11520, -11520, 11520);
    send_sample(300, 500, 1024, 5761, -5761, -5761);
    send_sample(-300, 700, 1024, 11521, -11521, 0);
    send_sample(-32768, 32767, -32768, -16384, 16383, -16384);
    send_sample(0, 0, 1024, 0, 0, 0);
  endtask

  // left and blocked right twice, down and the clearing of the last move
  task automatic test_gestures();
    send_sample(0, 0, 1024, 0, 0, 0);
    send_sample(-2000, 0, 1024, 0, 0, 0);
    send_sample(2000, 0, 1024, 0, 0, 0);
    send_sample(2000, 0, 1024, 0, 0, 0);
    send_sample(-2000, 0, 1024, 0, 0, 0);
    send_sample(2000, 0, 1024, 0, 0, 0);
    send_sample(2000, 0, 3500, 0, 0, 0);
    send_sample(2000, 0, 1024, 0, 0, 0);
    send_sample(800, 0, 1024, 0, 0, 0);
    send_sample(800, 0, 1024, 640, -640, 0);
  endtask

  task automatic test_random(input int count);
    int base_x, base_z;
    base_x = 0;
    base_z = 1024;
    for (int n = 0; n < count; n++) begin
      if ((n % 200) == 100) calm = ~calm;
      if ($urandom_range(0, 99) < 60) begin
        base_x = $urandom_range(0, 3) == 0 ? int'($urandom_range(0, 6000)) - 3000 :
                 base_x + int'($urandom_range(0, 8000)) - 4000;
        if (base_x > 32767 || base_x < -32768) base_x = 0;
        base_z = $urandom_range(0, 7) == 0 ? int'($urandom_range(0, 6000)) - 2000 :
                 1024 + int'($urandom_range(0, 1600)) - 800;
        send_sample(base_x, int'($urandom_range(0, 600)) - 300, base_z,
                    int'($urandom_range(0, 1280)) - 640,
                    int'($urandom_range(0, 1280)) - 640,
                    $urandom_range(0, 3) == 0 ? int'($urandom_range(0, 640)) - 320 : 0);
      end else begin
        send_sample($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
    end
    calm = 1'b0;
  endtask

  task automatic test_thresholds();
    write_threshold(tcsd_pkg::REG_NOISE, 0);
    write_threshold(tcsd_pkg::REG_SWING, 0);
    test_random(150);
    write_threshold(tcsd_pkg::REG_NOISE, 32767);
    write_threshold(tcsd_pkg::REG_SWING, 32767);
    test_random(150);
    write_threshold(tcsd_pkg::REG_NOISE, $urandom_range(0, 2000));
    write_threshold(tcsd_pkg::REG_SWING, $urandom_range(0, 4000));
    test_random(300);
    write_threshold(tcsd_pkg::REG_NOISE, 1024);
    write_threshold(tcsd_pkg::REG_SWING, 1536);
  endtask

  task automatic test_pause_then_random();
    test_random(200);
    // hold the sender until the pipeline is empty, then resume
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending.size() == 0);
    test_random(425);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_extremes();
    test_gestures();
    test_thresholds();
    test_pause_then_random();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/tcsd_pkg.sv
rtl/tcsd_front.sv
rtl/tcsd_back.sv
rtl/tilt_compensated_swipe_detector_top.sv
rtl/tcsd_checker.sv
bench/tb.sv
